[hw/rtl/fvlc_pkg.sv]
package fvlc_pkg;

  localparam logic [7:0] SCALE_RESET        = 8'd33;
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
  localparam logic [5:0] MINUTES_WRAP       = 6'd60;
  localparam logic [2:0] LEVEL_MAX          = 3'd6;

  typedef struct packed {
    logic [11:0] pulse_count;
    logic [2:0]  limit_level;
    logic        override_press;
  } fvlc_in_t;

  typedef struct packed {
    logic [31:0] volume_pulses;
    logic        led_green;
    logic        led_yellow;
    logic        led_red;
    logic        valve_relay;
    logic        override_on;
    logic [5:0]  second_count;
    logic [5:0]  minute_count;
    logic        minute_done;
    logic [17:0] minute_pulse_sum;
  } fvlc_out_t;

  typedef struct packed {
    logic [31:0] volume_total;
    logic        green_lamp;
    logic        yellow_lamp;
    logic        red_lamp;
    logic        relay_latch;
    logic        override_flag;
    logic [5:0]  seconds_reg;
    logic [5:0]  minutes_reg;
    logic [17:0] minute_sum;
  } fvlc_state_t;

  // Limit table rows in tenths of a litre. Unused level codes fall back to row 0.
  function automatic logic [7:0] lim_green(input logic [2:0] level);
    case (level)
      3'd1:    lim_green = 8'd20;
      3'd2:    lim_green = 8'd30;
      3'd3:    lim_green = 8'd40;
      3'd4:    lim_green = 8'd50;
      3'd5:    lim_green = 8'd60;
      3'd6:    lim_green = 8'd70;
      default: lim_green = 8'd10;
    endcase
  endfunction

  function automatic logic [7:0] lim_yellow(input logic [2:0] level);
    case (level)
      3'd1:    lim_yellow = 8'd33;
      3'd2:    lim_yellow = 8'd45;
      3'd3:    lim_yellow = 8'd65;
      3'd4:    lim_yellow = 8'd75;
      3'd5:    lim_yellow = 8'd85;
      3'd6:    lim_yellow = 8'd105;
      default: lim_yellow = 8'd15;
    endcase
  endfunction

  function automatic logic [7:0] lim_cut(input logic [2:0] level);
    case (level)
      3'd1:    lim_cut = 8'd40;
      3'd2:    lim_cut = 8'd60;
      3'd3:    lim_cut = 8'd80;
      3'd4:    lim_cut = 8'd100;
      3'd5:    lim_cut = 8'd120;
      3'd6:    lim_cut = 8'd140;
      default: lim_cut = 8'd20;
    endcase
  endfunction

endpackage

[hw/rtl/fvlc_eval.sv]
module fvlc_eval
  import fvlc_pkg::*;
(
  input  fvlc_in_t    item,
  input  fvlc_state_t state,
  input  logic [7:0]  scale,
  output fvlc_state_t state_next,
  output fvlc_out_t   result
);

  logic [2:0]  level;
  logic [32:0] vol_sum;
  logic [31:0] vol;
  logic [15:0] lim_t;
  logic [15:0] lim_y;
  logic [15:0] lim_x;
  logic        g;
  logic        yl;
  logic        r;
  logic        relay;
  logic        ovr;
  logic [18:0] msum_wide;
  logic [17:0] msum;
  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic        done;
  logic [17:0] closed_sum;

  assign level   = (item.limit_level > LEVEL_MAX) ? 3'd0 : item.limit_level;
  assign vol_sum = {1'b0, state.volume_total} + 33'(item.pulse_count);
  assign vol     = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];

  assign lim_t = 16'(lim_green(level)) * 16'(scale);
  assign lim_y = 16'(lim_yellow(level)) * 16'(scale);
  assign lim_x = 16'(lim_cut(level)) * 16'(scale);

  // Bands are checked in order; a later band wins, and equality keeps the old lamps.
  always_comb begin
    g     = state.green_lamp;
    yl    = state.yellow_lamp;
    r     = state.red_lamp;
    relay = state.relay_latch;
    if (vol != 32'd0 && vol < 32'(lim_t)) begin
      g = 1'b1; yl = 1'b0; r = 1'b0;
    end
    if (vol > 32'(lim_t) && vol < 32'(lim_y)) begin
      g = 1'b0; yl = 1'b1; r = 1'b0;
    end
    if (vol > 32'(lim_y) && vol < 32'(lim_x)) begin
      g = 1'b0; yl = 1'b0; r = 1'b1;
    end
    if (vol > 32'(lim_x) && !state.override_flag) begin
      relay = 1'b1;
      g = 1'b0; yl = 1'b0; r = 1'b1;
    end
    ovr = state.override_flag ^ item.override_press;
    if (ovr) begin
      relay = 1'b0;
      g = 1'b0; yl = 1'b0; r = 1'b0;
    end
  end

  assign msum_wide = {1'b0, state.minute_sum} + 19'(item.pulse_count);
  assign msum      = msum_wide[18] ? 18'h3FFFF : msum_wide[17:0];
  assign sec_inc   = state.seconds_reg + 6'd1;
  assign min_inc   = state.minutes_reg + 6'd1;
  assign done      = (sec_inc == SECONDS_PER_MINUTE);
  assign closed_sum = done ? msum : 18'd0;

  always_comb begin
    state_next.volume_total  = vol;
    state_next.green_lamp    = g;
    state_next.yellow_lamp   = yl;
    state_next.red_lamp      = r;
    state_next.relay_latch   = relay;
    state_next.override_flag = ovr;
    state_next.seconds_reg   = done ? 6'd0 : sec_inc;
    state_next.minutes_reg   = state.minutes_reg;
    state_next.minute_sum    = done ? 18'd0 : msum;
    if (done) begin
      state_next.minutes_reg = (min_inc >= MINUTES_WRAP) ? 6'd0 : min_inc;
    end
  end

  always_comb begin
    result.volume_pulses    = state_next.volume_total;
    result.led_green        = state_next.green_lamp;
    result.led_yellow       = state_next.yellow_lamp;
    result.led_red          = state_next.red_lamp;
    result.valve_relay      = state_next.relay_latch;
    result.override_on      = state_next.override_flag;
    result.second_count     = state_next.seconds_reg;
    result.minute_count     = state_next.minutes_reg;
    result.minute_done      = done;
    result.minute_pulse_sum = closed_sum;
  end

endmodule

[hw/rtl/flow_volume_limit_controller_top.sv]
// Flow volume limit controller. Each input word is one second of flow: the
// pulse count is added to a saturating total volume, which is compared with
// the green, yellow and cutoff limits of the chosen level (table in tenths of
// a litre times pulses_per_tenth_litre) to drive the lamps and the latched
// relay, and the override button toggles a flag that clears both. Seconds,
// minutes and each minute's pulse sum are kept as well. The block takes one
// word per clock cycle while the receiver does not stall the output; a word
// that is taken sits in the input register, and its result is loaded into
// the output register when the output may advance. The rate is set by the
// state update loop, which closes through the evaluation logic and the state
// registers.
module flow_volume_limit_controller_top
  import fvlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  fvlc_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output fvlc_out_t  out_data
);

  logic        in_full;
  fvlc_in_t    in_word;
  fvlc_state_t state;
  fvlc_state_t state_next;
  fvlc_out_t   result;
  logic [7:0]  scale;
  logic        advance;

  fvlc_eval u_eval (
    .item       (in_word),
    .state      (state),
    .scale      (scale),
    .state_next (state_next),
    .result     (result)
  );

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
      scale     <= SCALE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale <= cfg_data;
      end
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= in_full;
        if (in_full) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word <= in_data;
    end
    if (advance && in_full) begin
      out_data <= result;
    end
  end

endmodule

[tb/fvlc_result_checker.sv]
module fvlc_result_checker
  import fvlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  fvlc_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  fvlc_out_t  out_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Limit rows in tenths of a litre, row 0 in the low byte.
  localparam logic [6:0][7:0] GREEN_TENTHS  =
    {8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd10};
  localparam logic [6:0][7:0] YELLOW_TENTHS =
    {8'd105, 8'd85, 8'd75, 8'd65, 8'd45, 8'd33, 8'd15};
  localparam logic [6:0][7:0] CUTOFF_TENTHS =
    {8'd140, 8'd120, 8'd100, 8'd80, 8'd60, 8'd40, 8'd20};
  localparam int REPORT_LIMIT = 200;

  fvlc_state_t meter;
  logic [7:0]  scale;
  fvlc_out_t   expected_readings[$];
  fvlc_out_t   oldest;
  int          mismatches = 0;

  function automatic fvlc_out_t advance_meter(input fvlc_in_t w);
    logic [2:0]  row;
    logic [32:0] vol_sum;
    logic [31:0] vol;
    logic [31:0] green_lim;
    logic [31:0] yellow_lim;
    logic [31:0] cut_lim;
    logic [18:0] sum;
    logic [5:0]  secs;
    fvlc_out_t   r;
    row = (w.limit_level > LEVEL_MAX) ? 3'd0 : w.limit_level;
    vol_sum = {1'b0, meter.volume_total} + {21'd0, w.pulse_count};
    vol = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
    meter.volume_total = vol;
    green_lim  = {24'd0, GREEN_TENTHS[row]} * {24'd0, scale};
    yellow_lim = {24'd0, YELLOW_TENTHS[row]} * {24'd0, scale};
    cut_lim    = {24'd0, CUTOFF_TENTHS[row]} * {24'd0, scale};

    // Each band test is strict, so a volume sitting on a limit keeps the lamps.
    if (vol != 0 && vol < green_lim)
      {meter.green_lamp, meter.yellow_lamp, meter.red_lamp} = 3'b100;
    if (vol > green_lim && vol < yellow_lim)
      {meter.green_lamp, meter.yellow_lamp, meter.red_lamp} = 3'b010;
    if (vol > yellow_lim && vol < cut_lim)
      {meter.green_lamp, meter.yellow_lamp, meter.red_lamp} = 3'b001;
    // The cutoff looks at the override as it was before this word's press.
    if (vol > cut_lim && !meter.override_flag) begin
      meter.relay_latch = 1'b1;
      {meter.green_lamp, meter.yellow_lamp, meter.red_lamp} = 3'b001;
    end
    if (w.override_press)
      meter.override_flag = !meter.override_flag;
    if (meter.override_flag) begin
      meter.relay_latch = 1'b0;
      {meter.green_lamp, meter.yellow_lamp, meter.red_lamp} = 3'b000;
    end

    sum = {1'b0, meter.minute_sum} + {7'd0, w.pulse_count};
    meter.minute_sum = sum[18] ? 18'h3FFFF : sum[17:0];
    secs = meter.seconds_reg + 6'd1;
    r.minute_done = 1'b0;
    r.minute_pulse_sum = '0;
    if (secs == SECONDS_PER_MINUTE) begin
      meter.minutes_reg = (meter.minutes_reg + 6'd1 >= MINUTES_WRAP) ? 6'd0
                          : meter.minutes_reg + 6'd1;
      r.minute_done = 1'b1;
      r.minute_pulse_sum = meter.minute_sum;
      meter.minute_sum = '0;
      secs = '0;
    end
    meter.seconds_reg = secs;

    r.volume_pulses = meter.volume_total;
    r.led_green     = meter.green_lamp;
    r.led_yellow    = meter.yellow_lamp;
    r.led_red       = meter.red_lamp;
    r.valve_relay   = meter.relay_latch;
    r.override_on   = meter.override_flag;
    r.second_count  = meter.seconds_reg;
    r.minute_count  = meter.minutes_reg;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      // A badly broken block would otherwise flood the log.
      if (mismatches <= REPORT_LIMIT)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_reading(input fvlc_out_t want, input fvlc_out_t got);
    check_field("volume_pulses", want.volume_pulses, got.volume_pulses);
    check_field("led_green", 32'(want.led_green), 32'(got.led_green));
    check_field("led_yellow", 32'(want.led_yellow), 32'(got.led_yellow));
    check_field("led_red", 32'(want.led_red), 32'(got.led_red));
    check_field("valve_relay", 32'(want.valve_relay), 32'(got.valve_relay));
    check_field("override_on", 32'(want.override_on), 32'(got.override_on));
    check_field("second_count", 32'(want.second_count), 32'(got.second_count));
    check_field("minute_count", 32'(want.minute_count), 32'(got.minute_count));
    check_field("minute_done", 32'(want.minute_done), 32'(got.minute_done));
    check_field("minute_pulse_sum", 32'(want.minute_pulse_sum),
                32'(got.minute_pulse_sum));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      meter = '0;
      scale = SCALE_RESET;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        scale = cfg_data;
      // Compare before pushing so a word taken this edge cannot match itself.
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: expected no word, got volume %0d", $time,
                     out_data.volume_pulses);
        end else begin
          oldest = expected_readings.pop_front();
          check_reading(oldest, out_data);
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(advance_meter(in_data));
    end
    pending    <= expected_readings.size();
    fail_count <= mismatches;
  end

endmodule

[tb/tb_flow_volume_limit_controller_top.sv]
module tb_flow_volume_limit_controller_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fvlc_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  fvlc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fvlc_out_t   out_data;
  logic        stall_enable = 1'b0;
  int          stall_hold = 0;
  bit          sender_idles = 1'b1;
  int          cycle_count = 0;
  int          fail_count;
  int          pending;

  always #4 clk = ~clk;

  flow_volume_limit_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fvlc_result_checker meter_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int idle_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL flow_volume_limit_controller_top");
      $finish;
    end
  end

  // Receiver back-pressure: stall bursts between runs of free cycles.
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= idle_length();
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 12);
    end
  end

  // Valid stays high from one word to the next when there is no gap.
  task automatic send_second(input logic [11:0] pulses, input logic [2:0] level,
                             input logic press);
    int       gap;
    fvlc_in_t w;
    gap = sender_idles ? idle_length() : 0;
    w.pulse_count    = pulses;
    w.limit_level    = level;
    w.override_press = press;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_second(input bit bursts);
    int          p;
    logic [11:0] pulses;
    p = $urandom_range(0, 99);
    if (bursts && p < 3)
      pulses = 12'($urandom_range(0, 4095));
    else if (p < 13)
      pulses = 12'($urandom_range(0, 255));
    else
      pulses = 12'($urandom_range(0, 12));
    send_second(pulses, 3'($urandom_range(0, 7)), $urandom_range(0, 11) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_scale(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst          <= 1'b0;
    stall_enable <= 1'b1;

    // Directed seconds at the reset scale of 33 pulses per tenth litre.
    send_second(12'd0, 3'd0, 1'b0);    // zero volume leaves every lamp dark
    send_second(12'd100, 3'd0, 1'b0);  // green band
    send_second(12'd230, 3'd0, 1'b0);  // volume equal to the green limit
    send_second(12'd1, 3'd0, 1'b0);    // yellow band
    send_second(12'd164, 3'd0, 1'b0);  // volume equal to the yellow limit
    send_second(12'd1, 3'd7, 1'b0);    // unused level falls back to row 0, red
    send_second(12'd164, 3'd0, 1'b0);  // volume equal to the cutoff
    send_second(12'd0, 3'd6, 1'b0);    // higher row brings green back
    send_second(12'd200, 3'd1, 1'b1);  // override on clears the lamps
    send_second(12'd1000, 3'd5, 1'b0);
    send_second(12'd0, 3'd0, 1'b1);    // past cutoff but override still set
    send_second(12'd0, 3'd0, 1'b0);    // relay latches
    send_second(12'hFFF, 3'd6, 1'b0);
    send_second(12'hFFF, 3'd3, 1'b1);
    send_second(12'hFFF, 3'd2, 1'b1);
    send_second(12'd2048, 3'd4, 1'b0);
    drain();

    // Largest scale raises every limit; the cutoffs of rows 3 to 6 sit back above the volume.
    write_scale(8'd255);
    repeat (800) send_random_second(1'b0);
    drain();

    write_scale(8'd1);
    repeat (300) send_random_second(1'b1);
    drain();

    // Zero scale puts every limit at zero; no sender gaps here.
    write_scale(8'd0);
    sender_idles = 1'b0;
    repeat (150) send_random_second(1'b1);
    drain();
    sender_idles = 1'b1;

    repeat (4) begin
      write_scale(8'($urandom_range(2, 254)));
      repeat (90) send_random_second(1'b1);
      drain();
    end

    repeat (40) send_random_second(1'b1);
    drain();

    if (fail_count == 0) begin
      $display("PASS flow_volume_limit_controller_top");
    end else begin
      $display("FAIL flow_volume_limit_controller_top");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fvlc_pkg.sv
hw/rtl/fvlc_eval.sv
hw/rtl/flow_volume_limit_controller_top.sv
tb/fvlc_result_checker.sv
tb/tb_flow_volume_limit_controller_top.sv
